FILE: sv/utf16_to_utf8_encoder_macros.svh
// Assertion macros shared by the UTF-16 to UTF-8 encoder modules
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define U2U_CHK_IMPLY(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define U2U_CHK_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: sv/u2u_pkg.sv
// Package: shared types and constants for the UTF-16 to UTF-8 encoder
`default_nettype none

package u2u_pkg;

    localparam int JOB_BYTES     = 6;
    localparam int QUEUE_DEPTH   = 2;

    // Bytes caused by one code unit, byte 0 goes out first
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] data;
        logic [2:0]                cnt;
    } enc_job_t;

endpackage

`default_nettype wire

FILE: sv/utf16_to_utf8_encoder.sv
// Top level: UTF-16 code unit in, UTF-8 bytes out
// Usage:
//   Input channel: code_unit with last_unit, qualified by in_valid; a transfer
//   happens when in_valid is high and in_stall is low. last_unit flushes a
//   held high surrogate at the end of a string.
//   Output channel: out_byte with run_last, qualified by out_valid; a transfer
//   happens when out_valid is high and out_stall is low. run_last marks the
//   final byte caused by one input unit. A high surrogate that waits for its
//   low partner gives no bytes until the next unit.
//   A unit's first byte passes the job queue, then the output register.
//   Throughput: one byte per cycle while out_stall is low; a unit causes 1 to 6
//   bytes, which leave one by one through the byte-wide output register.
//   Units queue up to QUEUE_DEPTH jobs ahead of the output register.
//   While the receiver stalls, the output byte holds; once the queue fills,
//   in_stall rises.
//   Reset (rst_n low, asynchronous) drops the held surrogate, empties the
//   queue and clears out_valid.
`default_nettype none

module utf16_to_utf8_encoder
#(
    parameter int QUEUE_DEPTH = u2u_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] code_unit,
    input  wire logic        last_unit,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             run_last
);

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    u2u_pkg::enc_job_t push_job;
    u2u_pkg::enc_job_t head_job;

    u2u_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .code_unit (code_unit),
        .last_unit (last_unit),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    u2u_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    u2u_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

`default_nettype wire

FILE: sv/u2u_front.sv
// Front end: accepts code units, pairs surrogates and builds byte jobs
`default_nettype none
`include "utf16_to_utf8_encoder_macros.svh"

module u2u_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [15:0]       code_unit,
    input  wire logic              last_unit,
    input  wire logic              q_full,
    output logic                   q_push,
    output u2u_pkg::enc_job_t      q_job
);

    localparam logic [20:0] CP_BASE   = 21'h010000;
    localparam logic [20:0] LATIN_LO  = 21'h10FE00;
    localparam logic [20:0] LATIN_HI  = 21'h10FF00;

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      n;
    } bmp_t;

    function automatic bmp_t bmp_encode(input logic [15:0] u);
        bmp_t r;
        begin
            r.b = '0;
            if (u < 16'h0080)
            begin
                r.b[0] = u[7:0];
                r.n    = 2'd1;
            end
            else if (u < 16'h0800)
            begin
                r.b[0] = {3'b110, u[10:6]};
                r.b[1] = {2'b10, u[5:0]};
                r.n    = 2'd2;
            end
            else
            begin
                r.b[0] = {4'b1110, u[15:12]};
                r.b[1] = {2'b10, u[11:6]};
                r.b[2] = {2'b10, u[5:0]};
                r.n    = 2'd3;
            end
            return r;
        end
    endfunction

    logic        held_valid_reg;
    logic        held_valid_next;
    logic [9:0]  held_high_reg;
    logic [9:0]  held_high_next;

    logic        accept;
    logic        is_high;
    logic        is_low;
    logic        pair;
    logic        hold_new;
    logic        latin;
    logic [20:0] cp;
    bmp_t        pre_enc;
    bmp_t        unit_enc;
    u2u_pkg::enc_job_t job;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    assign is_high  = (code_unit[15:10] == 6'b110110);
    assign is_low   = (code_unit[15:10] == 6'b110111);
    assign pair     = held_valid_reg && is_low;
    assign hold_new = is_high && !last_unit;

    assign cp       = CP_BASE + {1'b0, held_high_reg, 10'b0} + {11'b0, code_unit[9:0]};
    assign latin    = (cp > LATIN_LO) && (cp < LATIN_HI);

    assign pre_enc  = bmp_encode({6'b110110, held_high_reg});
    assign unit_enc = bmp_encode(code_unit);

    always_comb
    begin
        job.data = '0;
        job.cnt  = 3'd0;
        if (pair)
        begin
            if (latin)
            begin
                job.data[0] = cp[7:0];
                job.cnt     = 3'd1;
            end
            else
            begin
                job.data[0] = {5'b11110, cp[20:18]};
                job.data[1] = {2'b10, cp[17:12]};
                job.data[2] = {2'b10, cp[11:6]};
                job.data[3] = {2'b10, cp[5:0]};
                job.cnt     = 3'd4;
            end
        end
        else
        begin
            if (held_valid_reg)
            begin
                job.data[2:0] = pre_enc.b;
                job.data[5:3] = unit_enc.b;
            end
            else
            begin
                job.data[2:0] = unit_enc.b;
            end
            job.cnt = (held_valid_reg ? 3'd3 : 3'd0)
                    + (hold_new ? 3'd0 : {1'b0, unit_enc.n});
        end
    end

    assign q_push = accept && (job.cnt != 3'd0);
    assign q_job  = job;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_high_next  = held_high_reg;
        if (accept)
        begin
            held_valid_next = !pair && hold_new;
            held_high_next  = (!pair && hold_new) ? code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_high_reg  <= 10'd0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_high_reg  <= held_high_next;
        end
    end

    `U2U_CHK_NEXT(a_pair_clears_hold, accept && pair, !held_valid_reg,
        "surrogate pair left a unit held")
    `U2U_CHK_IMPLY(a_hold_no_push, accept && !held_valid_reg && hold_new, !q_push,
        "held surrogate produced bytes")

endmodule

`default_nettype wire

FILE: sv/u2u_queue.sv
// Job queue between the front end and the byte sequencer
`default_nettype none
`include "utf16_to_utf8_encoder_macros.svh"

module u2u_queue
#(
    parameter int DEPTH = u2u_pkg::QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire u2u_pkg::enc_job_t push_job,
    input  wire logic              pop,
    output u2u_pkg::enc_job_t      head_job,
    output logic                   full,
    output logic                   empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u2u_pkg::enc_job_t mem_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `U2U_CHK_IMPLY(a_no_overflow, push, !full, "push into full queue")
    `U2U_CHK_IMPLY(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: sv/u2u_back.sv
// Back end: walks the head job one byte per transfer into the output register
`default_nettype none
`include "utf16_to_utf8_encoder_macros.svh"

module u2u_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire u2u_pkg::enc_job_t head_job,
    input  wire logic              q_empty,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             out_byte,
    output logic                   run_last
);

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       run_last_reg;
    logic       run_last_next;

    logic       load;
    logic       last_byte;

    assign load      = !q_empty && (!out_valid_reg || !out_stall);
    assign last_byte = (idx_reg == head_job.cnt - 3'd1);
    assign pop       = load && last_byte;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = head_job.data[idx_reg];
            run_last_next  = last_byte;
            idx_next       = last_byte ? 3'd0 : idx_reg + 3'd1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

    `U2U_CHK_NEXT(a_pop_marks_last, pop, out_valid_reg && run_last_reg,
        "job retired without last-byte mark")
    `U2U_CHK_IMPLY(a_idx_in_job, !q_empty, idx_reg < head_job.cnt,
        "byte index past end of job")

endmodule

`default_nettype wire
